FILE: rtl/twin_retractable_lamp_motor_controller_top_macros.svh
// assertion macro for the lamp controller checker
`ifndef TWIN_RETRACTABLE_LAMP_MOTOR_CONTROLLER_TOP_MACROS_SVH
`define TWIN_RETRACTABLE_LAMP_MOTOR_CONTROLLER_TOP_MACROS_SVH

`define TRL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`endif

FILE: rtl/trlmc_pkg.sv
// ----------------------------------------------------------------------------
// trlmc_pkg
// shared types and constants of the lamp motor controller
// ----------------------------------------------------------------------------
package trlmc_pkg;

  localparam int TimeWidthDefault = 32;
  localparam int HoldMin    = 20;
  localparam int HoldShort  = 500;
  localparam int WinkDwell  = 300;
  localparam int AltDwell   = 150;

  localparam logic [2:0] CfgLeftDuty     = 3'd0;
  localparam logic [2:0] CfgRightDuty    = 3'd1;
  localparam logic [2:0] CfgLeftSlpDown  = 3'd2;
  localparam logic [2:0] CfgRightSlpDown = 3'd3;
  localparam logic [2:0] CfgLeftSlpUp    = 3'd4;
  localparam logic [2:0] CfgRightSlpUp   = 3'd5;
  localparam logic [2:0] CfgDebounce     = 3'd6;
  localparam logic [2:0] CfgJam          = 3'd7;

  localparam logic [2:0] ModeFactory = 3'd0;
  localparam logic [2:0] ModeSleepy  = 3'd1;
  localparam logic [2:0] ModeWinkL   = 3'd2;
  localparam logic [2:0] ModeWinkR   = 3'd3;
  localparam logic [2:0] ModeAlt     = 3'd4;

  localparam logic [1:0] PosA       = 2'd0;
  localparam logic [1:0] PosB       = 2'd1;
  localparam logic [1:0] PosUnknown = 2'd2;

  typedef struct packed {
    logic       head_active;
    logic       latch_active;
    logic       wink_left_btn;
    logic       wink_right_btn;
    logic       sleepy_btn;
    logic       left_sense_a;
    logic       left_sense_b;
    logic       right_sense_a;
    logic       right_sense_b;
  } tick_t;

  typedef struct packed {
    logic [7:0] left_drive;
    logic [7:0] right_drive;
    logic       left_jam;
    logic       right_jam;
    logic [2:0] lamp_mode;
    logic [1:0] left_pos;
    logic [1:0] right_pos;
    logic       command_up;
  } result_t;

  typedef struct packed {
    logic [7:0]  left_duty;
    logic [7:0]  right_duty;
    logic [11:0] left_slp_down;
    logic [11:0] right_slp_down;
    logic [11:0] left_slp_up;
    logic [11:0] right_slp_up;
    logic [9:0]  debounce;
    logic [15:0] jam;
  } cfg_t;

  typedef struct packed {
    logic [2:0] idx;
    logic [15:0] data;
  } cfg_wr_t;

  function automatic logic [1:0] code_of(input logic a, input logic b);
    if (a && !b) return PosA;
    if (!a && b) return PosB;
    return PosUnknown;
  endfunction

endpackage

FILE: rtl/trlmc_if.sv
// ----------------------------------------------------------------------------
// trlmc_if
// valid/ready channel carrying one item
// ----------------------------------------------------------------------------
interface trlmc_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/trlmc_cfg.sv
// ----------------------------------------------------------------------------
// trlmc_cfg
// configuration register file
// ----------------------------------------------------------------------------
module trlmc_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  trlmc_if.sink             cfg,
  output trlmc_pkg::cfg_t   cfg_o
);
  import trlmc_pkg::*;

  cfg_t cfg_q;

  assign cfg.ready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_duty      <= 8'd180;
      cfg_q.right_duty     <= 8'd255;
      cfg_q.left_slp_down  <= 12'd240;
      cfg_q.right_slp_down <= 12'd240;
      cfg_q.left_slp_up    <= 12'd100;
      cfg_q.right_slp_up   <= 12'd200;
      cfg_q.debounce       <= 10'd50;
      cfg_q.jam            <= 16'd3000;
    end else if (cfg.valid) begin
      unique case (cfg.data.idx)
        CfgLeftDuty:     cfg_q.left_duty      <= cfg.data.data[7:0];
        CfgRightDuty:    cfg_q.right_duty     <= cfg.data.data[7:0];
        CfgLeftSlpDown:  cfg_q.left_slp_down  <= cfg.data.data[11:0];
        CfgRightSlpDown: cfg_q.right_slp_down <= cfg.data.data[11:0];
        CfgLeftSlpUp:    cfg_q.left_slp_up    <= cfg.data.data[11:0];
        CfgRightSlpUp:   cfg_q.right_slp_up   <= cfg.data.data[11:0];
        CfgDebounce:     cfg_q.debounce       <= cfg.data.data[9:0];
        CfgJam:          cfg_q.jam            <= cfg.data.data;
        default: ;
      endcase
    end
  end
endmodule

FILE: rtl/trlmc_core.sv
// ----------------------------------------------------------------------------
// trlmc_core
// per-tick state update: debounce, buttons, wink phases and motors
// ----------------------------------------------------------------------------
module trlmc_core #(
  parameter int TimeWidth = trlmc_pkg::TimeWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  trlmc_pkg::tick_t    tick_i,
  input  trlmc_pkg::cfg_t     cfg_i,
  output trlmc_pkg::result_t  res_o
);
  import trlmc_pkg::*;

  typedef logic [TimeWidth-1:0] tm_t;

  tm_t now_q, deb_mark_q, start_l_q, start_r_q, phase_mark_q;
  tm_t press_q [3];
  logic init_q, stable_q, pend_q, cmd_q, tgt_l_q, tgt_r_q, run_l_q, run_r_q;
  logic jam_l_q, jam_r_q, slp_on_q, timed_q;
  logic [1:0] bel_l_q, bel_r_q;
  logic [2:0] mode_q, phase_q, btn_q;
  logic [11:0] lim_l_q, lim_r_q;

  tm_t deb_mark_d, start_l_d, start_r_d, phase_mark_d;
  tm_t press_d [3];
  logic init_d, stable_d, pend_d, cmd_d, tgt_l_d, tgt_r_d, run_l_d, run_r_d;
  logic jam_l_d, jam_r_d, slp_on_d, timed_d;
  logic [1:0] bel_l_d, bel_r_d;
  logic [2:0] mode_d, phase_d;
  logic [11:0] lim_l_d, lim_r_d;
  logic [7:0] dl, dr;

  always_comb begin
    logic [1:0] raw_l, raw_r;
    logic raw_want, inv, wl, wr, slp;
    tm_t t, h;
    t = '0;
    h = '0;
    raw_l = code_of(tick_i.left_sense_a, tick_i.left_sense_b);
    raw_r = code_of(tick_i.right_sense_a, tick_i.right_sense_b);
    wl = tick_i.wink_left_btn;
    wr = tick_i.wink_right_btn;
    slp = tick_i.sleepy_btn;
    init_d = init_q; stable_d = stable_q; pend_d = pend_q; cmd_d = cmd_q;
    tgt_l_d = tgt_l_q; tgt_r_d = tgt_r_q; run_l_d = run_l_q; run_r_d = run_r_q;
    jam_l_d = jam_l_q; jam_r_d = jam_r_q; slp_on_d = slp_on_q; timed_d = timed_q;
    bel_l_d = bel_l_q; bel_r_d = bel_r_q; mode_d = mode_q; phase_d = phase_q;
    lim_l_d = lim_l_q; lim_r_d = lim_r_q;
    deb_mark_d = deb_mark_q; start_l_d = start_l_q; start_r_d = start_r_q;
    phase_mark_d = phase_mark_q;
    press_d = press_q;
    dl = '0; dr = '0;

    if (!init_q) begin
      init_d = 1'b1;
      stable_d = !tick_i.head_active;
      cmd_d = stable_d; pend_d = stable_d;
      tgt_l_d = cmd_d; tgt_r_d = cmd_d;
      bel_l_d = raw_l; bel_r_d = raw_r;
      if (bel_l_d != {1'b0, tgt_l_d}) begin run_l_d = 1'b1; start_l_d = now_q; end
      if (bel_r_d != {1'b0, tgt_r_d}) begin run_r_d = 1'b1; start_r_d = now_q; end
    end

    // stalk debounce
    if (!tick_i.head_active) raw_want = 1'b1;
    else if (!tick_i.latch_active) raw_want = stable_d;
    else raw_want = 1'b0;
    if (raw_want != pend_d) begin deb_mark_d = now_q; pend_d = raw_want; end
    if ((now_q - deb_mark_d) > tm_t'(cfg_i.debounce) && pend_d != stable_d) begin
      cmd_d = pend_d;
      mode_d = ModeFactory; slp_on_d = 1'b0; timed_d = 1'b0; phase_d = 3'd0;
      tgt_l_d = cmd_d; tgt_r_d = cmd_d;
      if (bel_l_d != {1'b0, cmd_d}) begin run_l_d = 1'b1; jam_l_d = 1'b0; start_l_d = now_q; end
      if (bel_r_d != {1'b0, cmd_d}) begin run_r_d = 1'b1; jam_r_d = 1'b0; start_r_d = now_q; end
      stable_d = pend_d;
    end
    inv = !cmd_d;

    // buttons
    if (wl && !btn_q[0]) press_d[0] = now_q;
    if (wr && !btn_q[1]) press_d[1] = now_q;
    if (slp && !btn_q[2]) press_d[2] = now_q;

    if (!slp && btn_q[2] && (now_q - press_d[2]) > tm_t'(HoldMin)) begin
      if (slp_on_d) begin
        slp_on_d = 1'b0; timed_d = 1'b0;
        mode_d = ModeFactory; tgt_l_d = cmd_d; tgt_r_d = cmd_d;
        run_l_d = 1'b1; start_l_d = now_q; bel_l_d = PosUnknown;
        run_r_d = 1'b1; start_r_d = now_q; bel_r_d = PosUnknown;
      end else if (mode_d == ModeFactory) begin
        slp_on_d = 1'b1; mode_d = ModeSleepy; timed_d = 1'b1;
        lim_l_d = cmd_d ? cfg_i.left_slp_up : cfg_i.left_slp_down;
        lim_r_d = cmd_d ? cfg_i.right_slp_up : cfg_i.right_slp_down;
        run_l_d = 1'b1; start_l_d = now_q; bel_l_d = PosUnknown;
        run_r_d = 1'b1; start_r_d = now_q; bel_r_d = PosUnknown;
      end
    end
    h = now_q - press_d[0];
    if (!wl && btn_q[0] && h > tm_t'(HoldMin) && h < tm_t'(HoldShort)
        && mode_d == ModeFactory) begin
      mode_d = ModeWinkL; phase_d = 3'd1;
    end
    h = now_q - press_d[1];
    if (!wr && btn_q[1] && h > tm_t'(HoldMin) && h < tm_t'(HoldShort)
        && mode_d == ModeFactory) begin
      mode_d = ModeWinkR; phase_d = 3'd1;
    end
    if (wl && wr && (now_q - press_d[0]) > tm_t'(HoldShort)
        && (now_q - press_d[1]) > tm_t'(HoldShort) && mode_d == ModeFactory) begin
      mode_d = ModeAlt; phase_d = 3'd1;
    end
    if (mode_d == ModeAlt && (!wl || !wr)) begin
      mode_d = ModeFactory; tgt_l_d = cmd_d; tgt_r_d = cmd_d;
      run_l_d = 1'b1; start_l_d = now_q; bel_l_d = PosUnknown;
      run_r_d = 1'b1; start_r_d = now_q; bel_r_d = PosUnknown;
    end

    // wink sequences
    if (mode_d == ModeWinkL) begin
      case (phase_d)
        3'd1: begin
          tgt_l_d = inv; run_l_d = 1'b1; start_l_d = now_q; bel_l_d = PosUnknown;
          timed_d = 1'b0; phase_d = 3'd2;
        end
        3'd2: if (!run_l_d) begin phase_mark_d = now_q; phase_d = 3'd3; end
        3'd3: if ((now_q - phase_mark_d) > tm_t'(WinkDwell)) begin
          tgt_l_d = cmd_d; run_l_d = 1'b1; start_l_d = now_q; bel_l_d = PosUnknown;
          phase_d = 3'd4;
        end
        3'd4: if (!run_l_d) begin mode_d = ModeFactory; phase_d = 3'd0; end
        default: ;
      endcase
    end
    if (mode_d == ModeWinkR) begin
      case (phase_d)
        3'd1: begin
          tgt_r_d = inv; run_r_d = 1'b1; start_r_d = now_q; bel_r_d = PosUnknown;
          timed_d = 1'b0; phase_d = 3'd2;
        end
        3'd2: if (!run_r_d) begin phase_mark_d = now_q; phase_d = 3'd3; end
        3'd3: if ((now_q - phase_mark_d) > tm_t'(WinkDwell)) begin
          tgt_r_d = cmd_d; run_r_d = 1'b1; start_r_d = now_q; bel_r_d = PosUnknown;
          phase_d = 3'd4;
        end
        3'd4: if (!run_r_d) begin mode_d = ModeFactory; phase_d = 3'd0; end
        default: ;
      endcase
    end
    if (mode_d == ModeAlt) begin
      case (phase_d)
        3'd1: begin
          tgt_l_d = inv; tgt_r_d = cmd_d;
          run_l_d = 1'b1; start_l_d = now_q; bel_l_d = PosUnknown;
          run_r_d = 1'b1; start_r_d = now_q; bel_r_d = PosUnknown;
          timed_d = 1'b0; phase_d = 3'd2;
        end
        3'd2: if (!run_l_d && !run_r_d) begin phase_mark_d = now_q; phase_d = 3'd3; end
        3'd3: if ((now_q - phase_mark_d) > tm_t'(AltDwell)) begin
          tgt_l_d = cmd_d; tgt_r_d = inv;
          run_l_d = 1'b1; start_l_d = now_q; bel_l_d = PosUnknown;
          run_r_d = 1'b1; start_r_d = now_q; bel_r_d = PosUnknown;
          phase_d = 3'd4;
        end
        3'd4: if (!run_l_d && !run_r_d) begin phase_mark_d = now_q; phase_d = 3'd5; end
        3'd5: if ((now_q - phase_mark_d) > tm_t'(AltDwell)) phase_d = 3'd1;
        default: ;
      endcase
    end

    // motors
    if (run_l_d && !jam_l_d) begin
      t = now_q - start_l_d;
      if ((timed_d && t >= tm_t'(lim_l_d)) || (!timed_d && raw_l == {1'b0, tgt_l_d})) begin
        run_l_d = 1'b0;
        bel_l_d = timed_d ? PosUnknown : {1'b0, tgt_l_d};
      end else if (t > tm_t'(cfg_i.jam)) begin
        run_l_d = 1'b0; jam_l_d = 1'b1;
      end else begin
        dl = cfg_i.left_duty;
      end
    end
    if (run_r_d && !jam_r_d) begin
      t = now_q - start_r_d;
      if ((timed_d && t >= tm_t'(lim_r_d)) || (!timed_d && raw_r == {1'b0, tgt_r_d})) begin
        run_r_d = 1'b0;
        bel_r_d = timed_d ? PosUnknown : {1'b0, tgt_r_d};
      end else if (t > tm_t'(cfg_i.jam)) begin
        run_r_d = 1'b0; jam_r_d = 1'b1;
      end else begin
        dr = cfg_i.right_duty;
      end
    end
  end

  always_comb begin
    res_o.left_drive  = dl;
    res_o.right_drive = dr;
    res_o.left_jam    = jam_l_d;
    res_o.right_jam   = jam_r_d;
    res_o.lamp_mode   = mode_d;
    res_o.left_pos    = bel_l_d;
    res_o.right_pos   = bel_r_d;
    res_o.command_up  = cmd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0; deb_mark_q <= '0; start_l_q <= '0; start_r_q <= '0;
      phase_mark_q <= '0;
      press_q[0] <= '0; press_q[1] <= '0; press_q[2] <= '0;
      init_q <= 1'b0; stable_q <= 1'b0; pend_q <= 1'b0; cmd_q <= 1'b0;
      tgt_l_q <= 1'b0; tgt_r_q <= 1'b0; run_l_q <= 1'b0; run_r_q <= 1'b0;
      jam_l_q <= 1'b0; jam_r_q <= 1'b0; slp_on_q <= 1'b0; timed_q <= 1'b0;
      bel_l_q <= PosUnknown; bel_r_q <= PosUnknown;
      mode_q <= ModeFactory; phase_q <= 3'd0; btn_q <= 3'd0;
      lim_l_q <= '0; lim_r_q <= '0;
    end else if (en_i) begin
      now_q <= now_q + 1'b1; deb_mark_q <= deb_mark_d;
      start_l_q <= start_l_d; start_r_q <= start_r_d; phase_mark_q <= phase_mark_d;
      press_q <= press_d;
      init_q <= init_d; stable_q <= stable_d; pend_q <= pend_d; cmd_q <= cmd_d;
      tgt_l_q <= tgt_l_d; tgt_r_q <= tgt_r_d; run_l_q <= run_l_d; run_r_q <= run_r_d;
      jam_l_q <= jam_l_d; jam_r_q <= jam_r_d; slp_on_q <= slp_on_d; timed_q <= timed_d;
      bel_l_q <= bel_l_d; bel_r_q <= bel_r_d;
      mode_q <= mode_d; phase_q <= phase_d;
      btn_q <= {tick_i.sleepy_btn, tick_i.wink_right_btn, tick_i.wink_left_btn};
      lim_l_q <= lim_l_d; lim_r_q <= lim_r_d;
    end
  end
endmodule

FILE: rtl/twin_retractable_lamp_motor_controller_top.sv
// ----------------------------------------------------------------------------
// twin_retractable_lamp_motor_controller_top
// lamp motor controller, one millisecond tick item in, one result item out
// ----------------------------------------------------------------------------
// Each tick item is captured in an input register and its result is computed
// in one pass of logic into the result register, so a tick is accepted every
// clock while the input register is not stalled, and its result is offered
// from the result register. The input register stalls only while the result
// register is full and not being taken. Configuration writes are taken at any
// time and apply to ticks processed after them.
module twin_retractable_lamp_motor_controller_top #(
  parameter int TimeWidth = trlmc_pkg::TimeWidthDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  trlmc_if.sink   tick,
  trlmc_if.source result,
  trlmc_if.sink   cfg
);
  import trlmc_pkg::*;

  cfg_t    cfg_w;
  result_t res_w;
  tick_t   in_q;
  logic    in_vld_q, out_vld_q, step;
  result_t out_q;

  trlmc_cfg u_cfg (.clk_i, .rst_ni, .cfg, .cfg_o(cfg_w));

  assign step = in_vld_q && (!out_vld_q || result.ready);
  assign tick.ready = !in_vld_q || step;
  assign result.valid = out_vld_q;
  assign result.data = out_q;

  trlmc_core #(.TimeWidth(TimeWidth)) u_core (
    .clk_i, .rst_ni, .en_i(step), .tick_i(in_q), .cfg_i(cfg_w), .res_o(res_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (tick.ready) in_vld_q <= tick.valid;
      if (step) out_vld_q <= 1'b1;
      else if (result.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick.ready && tick.valid) in_q <= tick.data;
    if (step) out_q <= res_w;
  end
endmodule

FILE: rtl/trlmc_checker.sv
// ----------------------------------------------------------------------------
// trlmc_checker
// port-level checks of the lamp controller
// ----------------------------------------------------------------------------
`include "twin_retractable_lamp_motor_controller_top_macros.svh"

module trlmc_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             res_valid,
  input logic             res_ready,
  input trlmc_pkg::result_t res_data
);
  import trlmc_pkg::*;

  `TRL_ASSERT(a_hold, clk_i, rst_ni, res_valid && !res_ready |=> res_valid && $stable(res_data))
  `TRL_ASSERT(a_mode, clk_i, rst_ni, res_valid |-> res_data.lamp_mode <= ModeAlt)
  `TRL_ASSERT(a_ljam, clk_i, rst_ni, res_valid && res_data.left_jam |-> res_data.left_drive == 8'd0)
  `TRL_ASSERT(a_rjam, clk_i, rst_ni, res_valid && res_data.right_jam |-> res_data.right_drive == 8'd0)
endmodule

bind twin_retractable_lamp_motor_controller_top trlmc_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .res_valid(result.valid),
  .res_ready(result.ready), .res_data(result.data)
);

FILE: sim/twin_retractable_lamp_motor_controller_top_tb.sv
// ----------------------------------------------------------------------------
// twin_retractable_lamp_motor_controller_top_tb
// self-checking bench for the lamp motor controller
// ----------------------------------------------------------------------------
// Tick items are driven over the valid/ready channel with random gaps. A
// behavioral model of the controller kept in the bench predicts the result
// of every accepted tick. Results come back with random stalls and are
// compared field by field. The run covers directed rows, well-formed button
// gestures and stalk moves with random content, and several configurations.
module twin_retractable_lamp_motor_controller_top_tb;
  import trlmc_pkg::*;

  localparam int WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #6 clk_i = ~clk_i;

  trlmc_if #(.T(tick_t))   tick_ch ();
  trlmc_if #(.T(result_t)) res_ch ();
  trlmc_if #(.T(cfg_wr_t)) cfg_ch ();

  twin_retractable_lamp_motor_controller_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tick  (tick_ch.sink),
    .result(res_ch.source),
    .cfg   (cfg_ch.sink)
  );

  // lamp model state
  logic [31:0] cfg_v [8];
  logic [31:0] now_t, deb_mark, st_l, st_r, ph_mark;
  logic [31:0] press_t [3];
  logic        inited, stable_w, pend_w, cmd, tgt_l, tgt_r, run_l, run_r;
  logic        jam_l, jam_r, slp_on, timed;
  logic [1:0]  bel_l, bel_r;
  logic [2:0]  mode_m, phase_m, btn_p;
  logic [31:0] lim_l, lim_r;

  result_t     expected_q [$];
  int          errors = 0;
  int          n_res = 0;
  int          n_sent = 0;
  int          budget = 0;
  bit          hold_off = 1'b0;
  bit          stim_done = 1'b0;
  int          quiet = 0;

  function automatic logic [1:0] sensor_code(logic a, logic b);
    if (a && !b) return PosA;
    if (!a && b) return PosB;
    return PosUnknown;
  endfunction

  task automatic lamp_reset();
    cfg_v[CfgLeftDuty] = 180; cfg_v[CfgRightDuty] = 255;
    cfg_v[CfgLeftSlpDown] = 240; cfg_v[CfgRightSlpDown] = 240;
    cfg_v[CfgLeftSlpUp] = 100; cfg_v[CfgRightSlpUp] = 200;
    cfg_v[CfgDebounce] = 50; cfg_v[CfgJam] = 3000;
    now_t = 0; deb_mark = 0; st_l = 0; st_r = 0; ph_mark = 0;
    press_t[0] = 0; press_t[1] = 0; press_t[2] = 0;
    inited = 0; stable_w = 0; pend_w = 0; cmd = 0; tgt_l = 0; tgt_r = 0;
    run_l = 0; run_r = 0; jam_l = 0; jam_r = 0; slp_on = 0; timed = 0;
    bel_l = PosUnknown; bel_r = PosUnknown;
    mode_m = ModeFactory; phase_m = 0; btn_p = 0; lim_l = 0; lim_r = 0;
  endtask

  task automatic move_l();
    run_l = 1; st_l = now_t; bel_l = PosUnknown;
  endtask

  task automatic move_r();
    run_r = 1; st_r = now_t; bel_r = PosUnknown;
  endtask

  task automatic to_factory();
    mode_m = ModeFactory; tgt_l = cmd; tgt_r = cmd;
    move_l(); move_r();
  endtask

  task automatic drive_motor(inout logic run, inout logic jam, input logic [31:0] st,
                             input logic [31:0] lim, input logic [1:0] raw,
                             input logic tgt, inout logic [1:0] bel,
                             input logic [31:0] duty, output logic [7:0] drv);
    logic [31:0] t;
    drv = 0;
    t = now_t - st;
    if (run && !jam) begin
      if ((timed && t >= lim) || (!timed && raw == {1'b0, tgt})) begin
        run = 0;
        bel = timed ? PosUnknown : {1'b0, tgt};
      end else if (t > cfg_v[CfgJam]) begin
        run = 0; jam = 1;
      end else begin
        drv = duty[7:0];
      end
    end
  endtask

  task automatic predict_tick(input tick_t tk, output result_t r);
    logic [1:0]  raw_l, raw_r;
    logic        raw_w, inv, wl, wr, sl;
    logic [31:0] h;
    logic [7:0]  dl, dr;
    wl = tk.wink_left_btn; wr = tk.wink_right_btn; sl = tk.sleepy_btn;
    raw_l = sensor_code(tk.left_sense_a, tk.left_sense_b);
    raw_r = sensor_code(tk.right_sense_a, tk.right_sense_b);
    if (!inited) begin
      inited = 1; stable_w = !tk.head_active; cmd = stable_w; pend_w = stable_w;
      tgt_l = cmd; tgt_r = cmd; bel_l = raw_l; bel_r = raw_r;
      if (bel_l != {1'b0, tgt_l}) begin run_l = 1; st_l = now_t; end
      if (bel_r != {1'b0, tgt_r}) begin run_r = 1; st_r = now_t; end
    end
    if (!tk.head_active) raw_w = 1;
    else if (!tk.latch_active) raw_w = stable_w;
    else raw_w = 0;
    if (raw_w != pend_w) begin deb_mark = now_t; pend_w = raw_w; end
    if (now_t - deb_mark > cfg_v[CfgDebounce] && pend_w != stable_w) begin
      cmd = pend_w; mode_m = ModeFactory; slp_on = 0; timed = 0; phase_m = 0;
      tgt_l = cmd; tgt_r = cmd;
      if (bel_l != {1'b0, cmd}) begin run_l = 1; jam_l = 0; st_l = now_t; end
      if (bel_r != {1'b0, cmd}) begin run_r = 1; jam_r = 0; st_r = now_t; end
      stable_w = pend_w;
    end
    inv = !cmd;
    if (wl && !btn_p[0]) press_t[0] = now_t;
    if (wr && !btn_p[1]) press_t[1] = now_t;
    if (sl && !btn_p[2]) press_t[2] = now_t;
    if (!sl && btn_p[2] && now_t - press_t[2] > HoldMin) begin
      if (slp_on) begin
        slp_on = 0; timed = 0; to_factory();
      end else if (mode_m == ModeFactory) begin
        slp_on = 1; mode_m = ModeSleepy; timed = 1;
        lim_l = cmd ? cfg_v[CfgLeftSlpUp] : cfg_v[CfgLeftSlpDown];
        lim_r = cmd ? cfg_v[CfgRightSlpUp] : cfg_v[CfgRightSlpDown];
        move_l(); move_r();
      end
    end
    if (!wl && btn_p[0]) begin
      h = now_t - press_t[0];
      if (h > HoldMin && h < HoldShort && mode_m == ModeFactory) begin
        mode_m = ModeWinkL; phase_m = 1;
      end
    end
    if (!wr && btn_p[1]) begin
      h = now_t - press_t[1];
      if (h > HoldMin && h < HoldShort && mode_m == ModeFactory) begin
        mode_m = ModeWinkR; phase_m = 1;
      end
    end
    if (wl && wr && now_t - press_t[0] > HoldShort && now_t - press_t[1] > HoldShort
        && mode_m == ModeFactory) begin
      mode_m = ModeAlt; phase_m = 1;
    end
    if (mode_m == ModeAlt && (!wl || !wr)) to_factory();
    btn_p = {sl, wr, wl};
    if (mode_m == ModeWinkL) begin
      case (phase_m)
        1: begin tgt_l = inv; move_l(); timed = 0; phase_m = 2; end
        2: if (!run_l) begin ph_mark = now_t; phase_m = 3; end
        3: if (now_t - ph_mark > WinkDwell) begin tgt_l = cmd; move_l(); phase_m = 4; end
        4: if (!run_l) begin mode_m = ModeFactory; phase_m = 0; end
        default: ;
      endcase
    end
    if (mode_m == ModeWinkR) begin
      case (phase_m)
        1: begin tgt_r = inv; move_r(); timed = 0; phase_m = 2; end
        2: if (!run_r) begin ph_mark = now_t; phase_m = 3; end
        3: if (now_t - ph_mark > WinkDwell) begin tgt_r = cmd; move_r(); phase_m = 4; end
        4: if (!run_r) begin mode_m = ModeFactory; phase_m = 0; end
        default: ;
      endcase
    end
    if (mode_m == ModeAlt) begin
      case (phase_m)
        1: begin
          tgt_l = inv; tgt_r = cmd; move_l(); move_r(); timed = 0; phase_m = 2;
        end
        2: if (!run_l && !run_r) begin ph_mark = now_t; phase_m = 3; end
        3: if (now_t - ph_mark > AltDwell) begin
          tgt_l = cmd; tgt_r = inv; move_l(); move_r(); phase_m = 4;
        end
        4: if (!run_l && !run_r) begin ph_mark = now_t; phase_m = 5; end
        5: if (now_t - ph_mark > AltDwell) phase_m = 1;
        default: ;
      endcase
    end
    drive_motor(run_l, jam_l, st_l, lim_l, raw_l, tgt_l, bel_l, cfg_v[CfgLeftDuty], dl);
    drive_motor(run_r, jam_r, st_r, lim_r, raw_r, tgt_r, bel_r, cfg_v[CfgRightDuty], dr);
    r.left_drive = dl; r.right_drive = dr; r.left_jam = jam_l; r.right_jam = jam_r;
    r.lamp_mode = mode_m; r.left_pos = bel_l; r.right_pos = bel_r; r.command_up = cmd;
    now_t = now_t + 1;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got %0d expected %0d", n_res, what, got, want);
    errors++;
  endtask

  // result side: random stalls, long hold-offs requested by stimulus
  initial begin
    int gap;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        res_ch.ready <= 1'b0;
        repeat (40) @(posedge clk_i);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 9) < 6) ? 0 :
            (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    result_t e, g;
    if (res_ch.valid && res_ch.ready) begin
      g = res_ch.data;
      if (expected_q.size() == 0) begin
        $display("result %0d arrived with nothing expected", n_res);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (g.left_drive !== e.left_drive) report_mismatch("left_drive", g.left_drive, e.left_drive);
        if (g.right_drive !== e.right_drive)
          report_mismatch("right_drive", g.right_drive, e.right_drive);
        if (g.left_jam !== e.left_jam) report_mismatch("left_jam", g.left_jam, e.left_jam);
        if (g.right_jam !== e.right_jam) report_mismatch("right_jam", g.right_jam, e.right_jam);
        if (g.lamp_mode !== e.lamp_mode) report_mismatch("lamp_mode", g.lamp_mode, e.lamp_mode);
        if (g.left_pos !== e.left_pos) report_mismatch("left_pos", g.left_pos, e.left_pos);
        if (g.right_pos !== e.right_pos) report_mismatch("right_pos", g.right_pos, e.right_pos);
        if (g.command_up !== e.command_up)
          report_mismatch("command_up", g.command_up, e.command_up);
      end
      n_res++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || stim_done && expected_q.size() == 0)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("timeout: nothing accepted for %0d cycles", WatchLimit);
      $display("Regression FAIL");
      $finish;
    end
  end

  // valid stays up after an accept so items can follow back to back
  task automatic send_tick(input tick_t tk, input bit check_row, input result_t row_res);
    result_t r;
    int gap;
    if (n_sent >= budget) return;
    gap = ($urandom_range(0, 9) < 7) ? 0 :
          (($urandom_range(0, 29) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3));
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.data <= tk;
    do @(posedge clk_i); while (!tick_ch.ready);
    predict_tick(tk, r);
    if (check_row && r !== row_res) begin
      $display("directed row %0d: model disagrees with typed result", n_sent);
      errors++;
    end
    expected_q.push_back(r);
    n_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input int data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{idx: idx, data: data[15:0]};
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
    case (idx) inside
      CfgLeftDuty, CfgRightDuty: cfg_v[idx] = {24'd0, data[7:0]};
      CfgDebounce: cfg_v[idx] = {22'd0, data[9:0]};
      CfgJam: cfg_v[idx] = {16'd0, data[15:0]};
      default: cfg_v[idx] = {20'd0, data[11:0]};
    endcase
  endtask

  task automatic drain();
    tick_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // lamp sensors follow targets most of the time, so motors reach position
  function automatic tick_t gesture_tick(logic hd, logic lt, logic [2:0] btn, int noise);
    tick_t t;
    t.head_active = hd; t.latch_active = lt;
    t.wink_left_btn = btn[0]; t.wink_right_btn = btn[1]; t.sleepy_btn = btn[2];
    if ($urandom_range(0, 99) < noise) begin
      {t.left_sense_a, t.left_sense_b, t.right_sense_a, t.right_sense_b} = 4'($urandom);
    end else begin
      t.left_sense_a = !tgt_l; t.left_sense_b = tgt_l;
      t.right_sense_a = !tgt_r; t.right_sense_b = tgt_r;
      if ($urandom_range(0, 3) != 0 && run_l && now_t - st_l < 30) begin
        t.left_sense_a = 1; t.left_sense_b = 1;
      end
      if ($urandom_range(0, 3) != 0 && run_r && now_t - st_r < 30) begin
        t.right_sense_a = 0; t.right_sense_b = 0;
      end
    end
    return t;
  endfunction

  task automatic hold_buttons(logic hd, logic [2:0] btn, int len);
    repeat (len) send_tick(gesture_tick(hd, 1'b1, btn, 5), 1'b0, '0);
  endtask

  initial begin
    typedef struct {
      tick_t   tk;
      bit      chk;
      result_t res;
    } row_t;
    row_t    rows [$];
    logic    hd;
    int      n, pick;
    tick_ch.valid = 1'b0; tick_ch.data = '0;
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    lamp_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: first tick aligns, head inactive means up, left already up,
    // right unknown so it drives at reset duty
    rows.push_back('{9'b0_0_000_01_11, 1'b1,
                     '{8'd0, 8'd255, 1'b0, 1'b0, ModeFactory, PosB, PosUnknown, 1'b1}});
    rows.push_back('{9'b0_0_000_01_01, 1'b1,
                     '{8'd0, 8'd0, 1'b0, 1'b0, ModeFactory, PosB, PosB, 1'b1}});
    rows.push_back('{9'b1_0_000_01_01, 1'b0, '0});
    rows.push_back('{9'b1_1_000_10_10, 1'b0, '0});
    rows.push_back('{9'b0_1_111_00_00, 1'b0, '0});
    rows.push_back('{9'b1_1_111_11_11, 1'b0, '0});
    rows.push_back('{9'b0_0_000_10_01, 1'b0, '0});
    budget = n_sent + rows.size();
    foreach (rows[i]) send_tick(rows[i].tk, rows[i].chk, rows[i].res);
    drain();

    // extreme, random and default configurations, including duty zero, debounce zero, jam zero
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(CfgLeftDuty, 255); write_reg(CfgRightDuty, 0);
          write_reg(CfgLeftSlpDown, 4095); write_reg(CfgRightSlpDown, 0);
          write_reg(CfgLeftSlpUp, 0); write_reg(CfgRightSlpUp, 4095);
          write_reg(CfgDebounce, 0); write_reg(CfgJam, 0);
        end
        1: begin
          write_reg(CfgLeftDuty, 0); write_reg(CfgRightDuty, 255);
          write_reg(CfgDebounce, 1023); write_reg(CfgJam, 65535);
        end
        2: begin
          for (int j = 0; j < 8; j++) write_reg(j[2:0], $urandom);
          write_reg(CfgDebounce, $urandom_range(0, 40));
          write_reg(CfgJam, $urandom_range(20, 400));
          write_reg(CfgLeftSlpUp, $urandom_range(0, 80));
        end
        default: begin
          write_reg(CfgLeftDuty, 180); write_reg(CfgRightDuty, 255);
          write_reg(CfgLeftSlpDown, 240); write_reg(CfgRightSlpDown, 240);
          write_reg(CfgLeftSlpUp, 100); write_reg(CfgRightSlpUp, 200);
          write_reg(CfgDebounce, 50); write_reg(CfgJam, 3000);
        end
      endcase
      n = (phase == 3) ? 680 : 220;
      budget = n_sent + n;
      hd = 1'($urandom);
      if (phase == 3) begin
        // results held back for a long stretch while ticks keep coming
        hold_off = 1'b1;
        hold_buttons(hd, 3'b000, 100);
      end
      while (n_sent < budget) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          // short wink on one side
          hold_buttons(hd, 3'b000, $urandom_range(1, 10));
          hold_buttons(hd, $urandom_range(0, 1) ? 3'b001 : 3'b010, $urandom_range(15, 520));
          hold_buttons(hd, 3'b000, $urandom_range(50, 700));
        end else if (pick < 35) begin
          // sleepy on, then off
          hold_buttons(hd, 3'b100, $urandom_range(18, 60));
          hold_buttons(hd, 3'b000, $urandom_range(50, 300));
          hold_buttons(hd, 3'b100, $urandom_range(18, 60));
          hold_buttons(hd, 3'b000, $urandom_range(5, 100));
        end else if (pick < 50) begin
          // both wink buttons held for alternating
          hold_buttons(hd, 3'b011, $urandom_range(490, 1100));
          hold_buttons(hd, 3'b000, $urandom_range(5, 50));
        end else if (pick < 65) begin
          // stalk move, with latch released sometimes
          hd = !hd;
          repeat ($urandom_range(1, 70))
            send_tick(gesture_tick(hd, $urandom_range(0, 3) != 0, 3'b000, 5), 1'b0, '0);
          hold_buttons(hd, 3'b000, $urandom_range(20, 200));
        end else if (pick < 72) begin
          // sensors stuck so motors jam
          repeat ($urandom_range(20, 420))
            send_tick(gesture_tick(hd, 1'b1, 3'b000, 100) & 9'b1_1111_0000 | 9'b0_0000_1111,
                      1'b0, '0);
        end else if (pick < 75 && phase == 2) begin
          // let the input back up while results are held
          hold_off = 1'b1;
          hold_buttons(hd, 3'b000, 60);
        end else begin
          repeat ($urandom_range(5, 40))
            send_tick(tick_t'(9'($urandom)), 1'b0, '0);
        end
      end
      drain();
    end

    stim_done = 1'b1;
    drain();
    repeat (10) @(posedge clk_i);
    $display("covered %0d ticks: stalk moves, winks, sleepy and alternating modes, jams,",
             n_sent);
    $display("and extreme register settings; %0d results checked", n_res);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/trlmc_pkg.sv
rtl/trlmc_if.sv
rtl/trlmc_cfg.sv
rtl/trlmc_core.sv
rtl/twin_retractable_lamp_motor_controller_top.sv
rtl/trlmc_checker.sv
sim/twin_retractable_lamp_motor_controller_top_tb.sv
